/* hdl/scb_pkg.sv */
// shared types, constants and reset values for the shape confidence blend unit
// no dependencies
package scb_pkg;

  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 17;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // shared divider: 43 bit dividend covers 2^42, 32 bit divisor covers sigma^2
  localparam int DIV_W     = 43;
  localparam int DIVISOR_W = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_CONF = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGMA_MIN  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGMA_MAX  = 8'd3;

  localparam logic [16:0] COLOR_CONF_RST = 17'd0;
  localparam logic [15:0] CUTOFF_RST     = 16'd55706;
  localparam logic [15:0] SIGMA_MIN_RST  = 16'd512;
  localparam logic [15:0] SIGMA_MAX_RST  = 16'd7680;
  // reset sigma is 512, so 2^42 / 512^2 = 2^24
  localparam logic [31:0] INV_SIGMA_SQ_RST = 32'h0100_0000;

  typedef enum logic [2:0] {
    SG_IDLE,
    SG_CHECK,
    SG_DIV_R,
    SG_MUL_R2,
    SG_MUL_S,
    SG_SQUARE,
    SG_INV_START,
    SG_DIV_I
  } sg_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] inv_sigma_sq;
  } sigma_sts_t;

endpackage

/* hdl/scb_div.sv */
// restoring divider, one quotient bit per cycle
// depends on scb_pkg
module scb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  scb_pkg::div_req_t req,
  output scb_pkg::div_rsp_t rsp
);

  localparam int CntW = $clog2(scb_pkg::DIV_W + 1);

  logic                            busy_r;
  logic                            done_r;
  logic [CntW-1:0]                 cnt_r;
  logic [scb_pkg::DIV_W-1:0]       dvd_r;
  logic [scb_pkg::DIVISOR_W-1:0]   dvs_r;
  logic [scb_pkg::DIVISOR_W-1:0]   rem_r;
  logic [scb_pkg::DIVISOR_W:0]     trial;
  logic                            qbit;

  assign trial = {rem_r, dvd_r[scb_pkg::DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(scb_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? scb_pkg::DIVISOR_W'(trial - {1'b0, dvs_r})
                    : trial[scb_pkg::DIVISOR_W-1:0];
      dvd_r <= {dvd_r[scb_pkg::DIV_W-2:0], qbit};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

/* hdl/scb_sigma.sv */
// configuration registers and the sequencer that derives inv_sigma_sq
// depends on scb_pkg and scb_div
module scb_sigma (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output scb_pkg::sigma_sts_t                sts
);

  scb_pkg::sg_state_t state_r, state_nxt;
  scb_pkg::div_req_t  div_req;
  scb_pkg::div_rsp_t  div_rsp;

  logic [16:0] cc_r;
  logic [15:0] cut_r;
  logic [15:0] smin_r;
  logic [15:0] smax_r;
  logic [31:0] inv_r;
  logic [16:0] r16_r;
  logic [16:0] r2_r;
  logic [15:0] s_r;
  logic [31:0] ss_r;

  logic        cfg_wr;
  logic        reg_hit;
  logic        in_range;
  logic [16:0] t_val;
  logic [16:0] den;
  logic [33:0] r16_sq;
  logic [15:0] dl;
  logic [32:0] dl_prod;
  logic [15:0] delta;

  assign cfg_ready = (state_r == scb_pkg::SG_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index)
      scb_pkg::REG_COLOR_CONF,
      scb_pkg::REG_CUTOFF,
      scb_pkg::REG_SIGMA_MIN,
      scb_pkg::REG_SIGMA_MAX: reg_hit = 1'b1;
      default:                reg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= scb_pkg::COLOR_CONF_RST;
      cut_r  <= scb_pkg::CUTOFF_RST;
      smin_r <= scb_pkg::SIGMA_MIN_RST;
      smax_r <= scb_pkg::SIGMA_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        scb_pkg::REG_COLOR_CONF: cc_r   <= cfg_data;
        scb_pkg::REG_CUTOFF:     cut_r  <= cfg_data[15:0];
        scb_pkg::REG_SIGMA_MIN:  smin_r <= cfg_data[15:0];
        scb_pkg::REG_SIGMA_MAX:  smax_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_range = (cc_r >= {1'b0, cut_r}) && (cc_r <= scb_pkg::ONE_Q16);
  assign t_val    = cc_r - {1'b0, cut_r};
  assign den      = scb_pkg::ONE_Q16 - {1'b0, cut_r};
  assign r16_sq   = 34'(r16_r) * 34'(r16_r);
  assign dl       = (smax_r >= smin_r) ? smax_r - smin_r : smin_r - smax_r;
  assign dl_prod  = 33'(dl) * 33'(r2_r);
  assign delta    = dl_prod[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scb_pkg::SG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = {10'b0, t_val, 16'b0};
    div_req.divisor  = {15'b0, den};
    unique case (state_r)
      scb_pkg::SG_IDLE: begin
        if (cfg_wr && reg_hit) state_nxt = scb_pkg::SG_CHECK;
      end
      scb_pkg::SG_CHECK: begin
        if (in_range) begin
          div_req.start = 1'b1;
          state_nxt     = scb_pkg::SG_DIV_R;
        end else begin
          state_nxt = scb_pkg::SG_SQUARE;
        end
      end
      scb_pkg::SG_DIV_R: begin
        if (div_rsp.done) state_nxt = scb_pkg::SG_MUL_R2;
      end
      scb_pkg::SG_MUL_R2: state_nxt = scb_pkg::SG_MUL_S;
      scb_pkg::SG_MUL_S:  state_nxt = scb_pkg::SG_SQUARE;
      scb_pkg::SG_SQUARE: state_nxt = scb_pkg::SG_INV_START;
      scb_pkg::SG_INV_START: begin
        div_req.dividend = {1'b1, 42'b0};
        div_req.divisor  = ss_r;
        if (ss_r == '0) begin
          state_nxt = scb_pkg::SG_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = scb_pkg::SG_DIV_I;
        end
      end
      scb_pkg::SG_DIV_I: begin
        if (div_rsp.done) state_nxt = scb_pkg::SG_IDLE;
      end
      default: state_nxt = scb_pkg::SG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= scb_pkg::INV_SIGMA_SQ_RST;
    end else begin
      unique case (state_r)
        scb_pkg::SG_CHECK: begin
          if (!in_range) s_r <= smin_r;
        end
        scb_pkg::SG_DIV_R: begin
          if (div_rsp.done) r16_r <= div_rsp.quotient[16:0];
        end
        scb_pkg::SG_MUL_R2: r2_r <= r16_sq[32:16];
        scb_pkg::SG_MUL_S: begin
          // sigma moves from the minimum toward the maximum, either direction
          s_r <= (smax_r >= smin_r) ? smin_r + delta : smin_r - delta;
        end
        scb_pkg::SG_SQUARE: ss_r <= 32'(s_r) * 32'(s_r);
        scb_pkg::SG_INV_START: begin
          if (ss_r == '0) inv_r <= '1;
        end
        scb_pkg::SG_DIV_I: begin
          if (div_rsp.done) begin
            inv_r <= (|div_rsp.quotient[42:32]) ? '1 : div_rsp.quotient[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  scb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign sts.busy         = (state_r != scb_pkg::SG_IDLE);
  assign sts.inv_sigma_sq = inv_r;

endmodule

/* hdl/scb_exp_rom.sv */
// constant exp(-16k/depth) table in Q1.16, two adjacent entries read per cycle while en is high
// depends on nothing but its parameter
module scb_exp_rom #(
  parameter int ExpTableDepth = 256
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [$clog2(ExpTableDepth+1)-1:0]      addr,
  output logic [16:0]                             a_r,
  output logic [16:0]                             b_r
);

  localparam int AddrW = $clog2(ExpTableDepth + 1);

  // long division by compare and subtract, evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series for exp(-16/depth) in Q30, terms floored
  function automatic logic [63:0] calc_e_step();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 30;
    pos  = term;
    neg  = '0;
    for (int i = 1; i <= 24; i++) begin
      term = udiv64(term * 64'd16, 64'(ExpTableDepth) * 64'(i));
      if ((i & 1) == 1) neg = neg + term;
      else              pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  localparam logic [63:0] E_STEP = calc_e_step();

  function automatic logic [16:0] exp_entry(input int k);
    logic [63:0] cur;
    logic [63:0] q;
    cur = 64'd1 << 30;
    for (int j = 0; j < k; j++) begin
      cur = (cur * E_STEP + (64'd1 << 29)) >> 30;
    end
    q = (cur + 64'd8192) >> 14;
    return (q > 64'd65536) ? 17'd65536 : q[16:0];
  endfunction

  logic [16:0]      rom [ExpTableDepth+1];
  logic [AddrW-1:0] addr_b;

  for (genvar k = 0; k <= ExpTableDepth; k++) begin : g_rom
    assign rom[k] = exp_entry(k);
  end

  assign addr_b = addr + 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= rom[addr];
      b_r <= rom[addr_b];
    end
  end

endmodule

/* hdl/shape_confidence_blend_unit.sv */
// top level: config sequencer plus seven stage pixel pipeline
// depends on scb_pkg, scb_sigma, scb_exp_rom
//
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   in_boundary_dist, in_is_foreground, in_color_prob
// out      out  out_valid / out_stall out_shape_conf, out_blended_prob
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one pixel per cycle while in_stall is low, which out_stall or a busy sigma sequencer raises
// stages: d^2, d^2*inv_sigma_sq, table index, table read, interpolate, blend product, sum
// a write to one of the four registers starts the sigma sequencer: with colour confidence in
// range it divides, squares, scales sigma, squares sigma and divides again, else it squares the
// minimum sigma and divides; a zero square saturates inv_sigma_sq without a divide; input stalls meanwhile
// rst_n is synchronous; reset loads the default registers and their inv_sigma_sq
// each stage holds while the one after it is full and stalled, bubbles collapse
module shape_confidence_blend_unit #(
  parameter int ExpTableDepth = scb_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_boundary_dist,
  input  logic                            in_is_foreground,
  input  logic [16:0]                     in_color_prob,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [16:0]                     out_shape_conf,
  output logic [16:0]                     out_blended_prob,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IdxW = $clog2(ExpTableDepth + 1);
  localparam int PosW = 20 + IdxW;

  scb_pkg::sigma_sts_t sts;

  logic [7:1] vld_r;
  logic [7:1] rdy;
  logic [7:1] ld;
  logic       in_acc;

  logic [31:0]     dd1_r;
  logic            lab1_r, lab2_r, lab3_r, lab4_r, lab5_r, lab6_r;
  logic [16:0]     cp1_r, cp2_r, cp3_r, cp4_r, cp5_r;
  logic            over2_r, over3_r, over4_r;
  logic [19:0]     xq2_r;
  logic [IdxW-1:0] idx3_r;
  logic [19:0]     frac3_r, frac4_r;
  logic [16:0]     a4_r, b4_r;
  logic [16:0]     fs5_r, fs6_r;
  logic [33:0]     p6_r;
  logic [16:0]     out_shape_conf_r;
  logic [16:0]     out_blended_prob_r;

  logic [63:0]     prod2;
  logic [PosW-1:0] pos3;
  logic [IdxW-1:0] idx3;
  logic [16:0]     diff5;
  logic [36:0]     dmul5;
  logic [16:0]     ev5;
  logic [16:0]     ev5_sat;
  logic [34:0]     acc7;
  logic [18:0]     sh7;

  scb_sigma u_sigma (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts)
  );

  always_comb begin
    rdy[7] = !vld_r[7] || !out_stall;
    for (int k = 6; k >= 1; k--) rdy[k] = !vld_r[k] || rdy[k+1];
    ld[1] = in_acc;
    for (int k = 2; k <= 7; k++) ld[k] = rdy[k] && vld_r[k-1];
  end

  assign in_stall  = !rdy[1] || sts.busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = vld_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_acc;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 1: square the distance, clamp the colour probability
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      dd1_r  <= 32'(in_boundary_dist) * 32'(in_boundary_dist);
      lab1_r <= in_is_foreground;
      cp1_r  <= (in_color_prob > scb_pkg::ONE_Q16) ? scb_pkg::ONE_Q16 : in_color_prob;
    end
  end

  // stage 2: exponent x in Q.16, flag x at or beyond 16.0
  assign prod2 = 64'(dd1_r) * 64'(sts.inv_sigma_sq);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      over2_r <= |prod2[63:46];
      xq2_r   <= prod2[45:26];
      lab2_r  <= lab1_r;
      cp2_r   <= cp1_r;
    end
  end

  // stage 3: table position, 20 fraction bits
  assign pos3 = PosW'(xq2_r) * PosW'(ExpTableDepth);
  assign idx3 = (pos3[PosW-1:20] >= IdxW'(ExpTableDepth)) ? IdxW'(ExpTableDepth - 1)
                                                          : pos3[PosW-1:20];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      idx3_r  <= idx3;
      frac3_r <= pos3[19:0];
      over3_r <= over2_r;
      lab3_r  <= lab2_r;
      cp3_r   <= cp2_r;
    end
  end

  // stage 4: read both neighbors
  scb_exp_rom #(
    .ExpTableDepth (ExpTableDepth)
  ) u_rom (
    .clk  (clk),
    .en   (ld[4]),
    .addr (idx3_r),
    .a_r  (a4_r),
    .b_r  (b4_r)
  );

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      frac4_r <= frac3_r;
      over4_r <= over3_r;
      lab4_r  <= lab3_r;
      cp4_r   <= cp3_r;
    end
  end

  // stage 5: linear interpolation, floor toward the first entry
  assign diff5   = (a4_r >= b4_r) ? a4_r - b4_r : b4_r - a4_r;
  assign dmul5   = 37'(diff5) * 37'(frac4_r);
  assign ev5     = (a4_r >= b4_r) ? a4_r - dmul5[36:20] : a4_r + dmul5[36:20];
  assign ev5_sat = over4_r ? 17'd0 : ((ev5 > scb_pkg::ONE_Q16) ? scb_pkg::ONE_Q16 : ev5);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      fs5_r  <= scb_pkg::ONE_Q16 - ev5_sat;
      lab5_r <= lab4_r;
      cp5_r  <= cp4_r;
    end
  end

  // stage 6: colour share of the blend
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      p6_r   <= 34'(scb_pkg::ONE_Q16 - fs5_r) * 34'(cp5_r);
      fs6_r  <= fs5_r;
      lab6_r <= lab5_r;
    end
  end

  // stage 7: add label share, round, saturate
  assign acc7 = (lab6_r ? {2'b0, fs6_r, 16'b0} : 35'd0) + {1'b0, p6_r} + 35'd32768;
  assign sh7  = acc7[34:16];

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      out_shape_conf_r   <= fs6_r;
      out_blended_prob_r <= (sh7 > 19'(scb_pkg::ONE_Q16)) ? scb_pkg::ONE_Q16 : sh7[16:0];
    end
  end

  assign out_shape_conf   = out_shape_conf_r;
  assign out_blended_prob = out_blended_prob_r;

  a_no_pixel_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !sts.busy)
    else $error("pixel request taken while sigma is being derived");

  a_write_starts_seq : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == scb_pkg::REG_COLOR_CONF ||
      cfg_index == scb_pkg::REG_SIGMA_MAX) |=> sts.busy)
    else $error("register write did not start the sigma sequencer");

  a_index_in_table : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> idx3_r < IdxW'(ExpTableDepth))
    else $error("table index beyond last interval");

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shape_conf <= scb_pkg::ONE_Q16) &&
                  (out_blended_prob <= scb_pkg::ONE_Q16))
    else $error("result above one");

endmodule
